// File: sv/rle_sprite_clip_blitter_top_assert.svh
// Assertion macros for the sprite blitter RTL.
`ifndef RLE_SPRITE_CLIP_BLITTER_TOP_ASSERT_SVH
`define RLE_SPRITE_CLIP_BLITTER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define RSCB_ASSERT_IMPL(label, clk, rst, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error("rscb assertion failed");
`define RSCB_ASSERT_NEXT(label, clk, rst, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error("rscb assertion failed");
`else
`define RSCB_ASSERT_IMPL(label, clk, rst, cond, conseq)
`define RSCB_ASSERT_NEXT(label, clk, rst, cond, conseq)
`endif
`endif

// File: sv/rscb_pkg.sv
// Types and constants shared by the sprite blitter modules.
package rscb_pkg;

  localparam int CLIP_BITS      = 11;
  localparam int SIZE_BITS      = 10;
  localparam int RUN_BITS       = 7;
  localparam int CFG_INDEX_BITS = 3;

  localparam logic [CFG_INDEX_BITS-1:0] REG_ORIGIN_X      = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ORIGIN_Y      = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPRITE_WIDTH  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPRITE_HEIGHT = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CLIP_LEFT     = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CLIP_TOP      = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CLIP_RIGHT    = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CLIP_BOTTOM   = 3'd7;

  localparam logic [CLIP_BITS-1:0] CLIP_MAX = 11'd2047;

  typedef struct packed {
    logic       first_byte;
    logic [7:0] rle_byte;
  } byte_item_t;

  typedef struct packed {
    logic                 pixel_write;
    logic [CLIP_BITS-1:0] pixel_x;
    logic [CLIP_BITS-1:0] pixel_y;
    logic [7:0]           pixel_color;
    logic                 sprite_done;
  } pixel_item_t;

  // How the byte reads if the decoder expects a tag.
  typedef enum logic [1:0] {
    TAG_SKIP,
    TAG_END,
    TAG_LITERAL
  } tag_kind_t;

  typedef struct packed {
    logic                first;
    tag_kind_t           kind;
    logic [7:0]          data;
  } cmd_t;

endpackage

// File: sv/rscb_fifo.sv
// Small register FIFO used between the blitter stages and at the output.
module rscb_fifo #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  `include "rle_sprite_clip_blitter_top_assert.svh"

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
  localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

  logic [WIDTH-1:0]    mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  `RSCB_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= CNT_FULL)
  `RSCB_ASSERT_NEXT(a_push_fills, clk, rst, do_push && !do_pop, !empty)
  `RSCB_ASSERT_NEXT(a_last_pop, clk, rst, do_pop && !do_push && count == 1, empty)

endmodule

// File: sv/rscb_front.sv
// Front end: accepts coded bytes and classifies them for the decoder.
module rscb_front import rscb_pkg::*; (
  input  logic       push,
  input  byte_item_t byte_item,
  output logic       full,
  output logic       q_push,
  output cmd_t       q_cmd,
  input  logic       q_full
);

  assign full   = q_full;
  assign q_push = push && !q_full;

  always_comb begin
    q_cmd.first = byte_item.first_byte;
    q_cmd.data  = byte_item.rle_byte;
    if (byte_item.rle_byte[7]) begin
      q_cmd.kind = TAG_SKIP;
    end else if (byte_item.rle_byte == 8'd0) begin
      q_cmd.kind = TAG_END;
    end else begin
      q_cmd.kind = TAG_LITERAL;
    end
  end

endmodule

// File: sv/rscb_back.sv
// Back end: decode state, configuration registers, clipping and row wrap.
module rscb_back import rscb_pkg::*; #(
  parameter int COORD_BITS = 12,
  localparam int CFG_BITS = (COORD_BITS > CLIP_BITS) ? COORD_BITS : CLIP_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]       cfg_data,
  input  logic                      cmd_valid,
  input  cmd_t                      cmd,
  output logic                      cmd_pop,
  input  logic                      res_full,
  output logic                      res_push,
  output pixel_item_t               res
);

  `include "rle_sprite_clip_blitter_top_assert.svh"

  localparam int CW = CFG_BITS + 2;

  logic signed [COORD_BITS-1:0] origin_x;
  logic signed [COORD_BITS-1:0] origin_y;
  logic [SIZE_BITS-1:0]         sprite_width;
  logic [SIZE_BITS-1:0]         sprite_height;
  logic [CLIP_BITS-1:0]         clip_left;
  logic [CLIP_BITS-1:0]         clip_top;
  logic [CLIP_BITS-1:0]         clip_right;
  logic [CLIP_BITS-1:0]         clip_bottom;

  logic                expect_tag, expect_tag_next;
  logic [RUN_BITS-1:0] literal_left, literal_left_next;
  logic signed [CW-1:0] cursor_x, cursor_x_next;
  logic signed [CW-1:0] cursor_y, cursor_y_next;
  logic                finished, finished_next;

  logic signed [CW-1:0] ox, oy, wd, ht, cl, ct, cr, cb, run_len, x_end, y_end;
  logic                 run_end;
  logic                 active;
  logic                 has_res;
  logic                 in_clip;

  assign ox      = CW'(origin_x);
  assign oy      = CW'(origin_y);
  assign wd      = $signed({{(CW-SIZE_BITS){1'b0}}, sprite_width});
  assign ht      = $signed({{(CW-SIZE_BITS){1'b0}}, sprite_height});
  assign cl      = $signed({{(CW-CLIP_BITS){1'b0}}, clip_left});
  assign ct      = $signed({{(CW-CLIP_BITS){1'b0}}, clip_top});
  assign cr      = $signed({{(CW-CLIP_BITS){1'b0}}, clip_right});
  assign cb      = $signed({{(CW-CLIP_BITS){1'b0}}, clip_bottom});
  assign run_len = $signed({{(CW-RUN_BITS){1'b0}}, cmd.data[RUN_BITS-1:0]});
  assign x_end   = ox + wd;
  assign y_end   = oy + ht;
  assign in_clip = (cursor_x >= cl) && (cursor_x <= cr) &&
                   (cursor_y >= ct) && (cursor_y <= cb);

  assign cmd_pop  = cmd_valid && !res_full;
  assign res_push = cmd_pop && has_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x      <= '0;
      origin_y      <= '0;
      sprite_width  <= '0;
      sprite_height <= '0;
      clip_left     <= '0;
      clip_top      <= '0;
      clip_right    <= CLIP_MAX;
      clip_bottom   <= CLIP_MAX;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ORIGIN_X:      origin_x      <= cfg_data[COORD_BITS-1:0];
        REG_ORIGIN_Y:      origin_y      <= cfg_data[COORD_BITS-1:0];
        REG_SPRITE_WIDTH:  sprite_width  <= cfg_data[SIZE_BITS-1:0];
        REG_SPRITE_HEIGHT: sprite_height <= cfg_data[SIZE_BITS-1:0];
        REG_CLIP_LEFT:     clip_left     <= cfg_data[CLIP_BITS-1:0];
        REG_CLIP_TOP:      clip_top      <= cfg_data[CLIP_BITS-1:0];
        REG_CLIP_RIGHT:    clip_right    <= cfg_data[CLIP_BITS-1:0];
        REG_CLIP_BOTTOM:   clip_bottom   <= cfg_data[CLIP_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    expect_tag_next   = expect_tag;
    literal_left_next = literal_left;
    cursor_x_next     = cursor_x;
    cursor_y_next     = cursor_y;
    finished_next     = finished;
    run_end           = 1'b0;
    has_res           = 1'b0;
    res               = '0;
    if (cmd.first) begin
      expect_tag_next   = 1'b1;
      literal_left_next = '0;
      cursor_x_next     = ox;
      cursor_y_next     = oy;
      finished_next     = (ox > cr) || (oy > cb) || (sprite_height == '0);
      active            = !finished_next;
      has_res           = 1'b1;
    end else begin
      active = !finished;
    end
    if (active) begin
      has_res = 1'b1;
      if (expect_tag_next) begin
        unique case (cmd.kind)
          TAG_SKIP: begin
            cursor_x_next = cursor_x_next + run_len;
            run_end       = 1'b1;
          end
          TAG_END: begin
            run_end = 1'b1;
          end
          TAG_LITERAL: begin
            literal_left_next = cmd.data[RUN_BITS-1:0];
            expect_tag_next   = 1'b0;
          end
          default: ;
        endcase
      end else begin
        if (in_clip) begin
          res.pixel_write = 1'b1;
          res.pixel_x     = cursor_x[CLIP_BITS-1:0];
          res.pixel_y     = cursor_y[CLIP_BITS-1:0];
          res.pixel_color = cmd.data;
        end
        cursor_x_next     = cursor_x + CW'(1);
        literal_left_next = literal_left - 1'b1;
        if (literal_left_next == '0) begin
          expect_tag_next = 1'b1;
          run_end         = 1'b1;
        end
      end
      if (run_end && (cursor_x_next >= x_end)) begin
        cursor_x_next = ox;
        cursor_y_next = cursor_y_next + CW'(1);
        if ((cursor_y_next > cb) || (cursor_y_next >= y_end)) begin
          finished_next = 1'b1;
        end
      end
    end
    res.sprite_done = finished_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_tag   <= 1'b1;
      literal_left <= '0;
      cursor_x     <= '0;
      cursor_y     <= '0;
      finished     <= 1'b1;
    end else if (cmd_pop) begin
      expect_tag   <= expect_tag_next;
      literal_left <= literal_left_next;
      cursor_x     <= cursor_x_next;
      cursor_y     <= cursor_y_next;
      finished     <= finished_next;
    end
  end

  `RSCB_ASSERT_IMPL(a_push_on_pop, clk, rst, res_push, cmd_pop)
  `RSCB_ASSERT_IMPL(a_idle_silent, clk, rst, cmd_pop && finished && !cmd.first, !res_push)
  `RSCB_ASSERT_IMPL(a_literal_count, clk, rst, !expect_tag, literal_left != '0)
  `RSCB_ASSERT_IMPL(a_pixel_left, clk, rst, res_push && res.pixel_write, res.pixel_x >= clip_left)
  `RSCB_ASSERT_IMPL(a_pixel_right, clk, rst, res_push && res.pixel_write, res.pixel_x <= clip_right)

endmodule

// File: sv/rle_sprite_clip_blitter_top.sv
// Top level of the run-length sprite blitter with clip rectangle.
// A byte accepted into the command queue is decoded at the queue head and its result,
// if any, is registered into the result queue, after which empty goes low.
// Throughput: one coded byte per cycle while the result queue has room.
// Reset (synchronous, rst high): queues emptied, decoder idle until a first byte,
// registers at reset values (clip right and bottom 2047, others 0).
module rle_sprite_clip_blitter_top import rscb_pkg::*; #(
  parameter int COORD_BITS = 12,
  localparam int CFG_BITS = (COORD_BITS > CLIP_BITS) ? COORD_BITS : CLIP_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  byte_item_t                byte_item,
  output logic                      full,
  output logic                      empty,
  input  logic                      pop,
  output pixel_item_t               pixel_item,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]       cfg_data
);

  logic        q_push;
  logic        q_full;
  logic        q_empty;
  cmd_t        q_cmd;
  cmd_t        head_cmd;
  logic        cmd_pop;
  logic        res_push;
  logic        res_full;
  pixel_item_t res;

  rscb_front u_front (
    .push      (push),
    .byte_item (byte_item),
    .full      (full),
    .q_push    (q_push),
    .q_cmd     (q_cmd),
    .q_full    (q_full)
  );

  rscb_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (2)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_cmd),
    .full  (q_full),
    .pop   (cmd_pop),
    .rdata (head_cmd),
    .empty (q_empty)
  );

  rscb_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (!q_empty),
    .cmd       (head_cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  rscb_fifo #(
    .WIDTH ($bits(pixel_item_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (pixel_item),
    .empty (empty)
  );

endmodule

// File: tb/rle_sprite_clip_blitter_top_test.sv
// Self-checking testbench for the run-length sprite blitter: directed table, then random sprites.
module rle_sprite_clip_blitter_top_test;
  import rscb_pkg::*;

  localparam int COORD_BITS     = 12;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int RANDOM_ITEMS   = 440;

  typedef enum logic { ROW_REG, ROW_BYTE } row_kind_t;

  typedef struct packed {
    row_kind_t                 kind;
    logic [CFG_INDEX_BITS-1:0] reg_index;
    logic [COORD_BITS-1:0]     reg_value;
    byte_item_t                item;
    logic                      typed;
    pixel_item_t               want;
  } stim_row_t;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      push = 1'b0;
  byte_item_t                byte_item = '0;
  logic                      full;
  logic                      empty;
  logic                      pop = 1'b0;
  pixel_item_t               pixel_item;
  logic                      cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [COORD_BITS-1:0]     cfg_data = '0;

  // Predictor copy of the registers and decode state.
  logic signed [COORD_BITS-1:0] org_x = '0;
  logic signed [COORD_BITS-1:0] org_y = '0;
  logic [SIZE_BITS-1:0]         spr_w = '0;
  logic [SIZE_BITS-1:0]         spr_h = '0;
  logic [CLIP_BITS-1:0]         clip_l = '0;
  logic [CLIP_BITS-1:0]         clip_t = '0;
  logic [CLIP_BITS-1:0]         clip_r = CLIP_MAX;
  logic [CLIP_BITS-1:0]         clip_b = CLIP_MAX;
  bit                           want_tag = 1'b1;
  logic [RUN_BITS-1:0]          lits_left = '0;
  int                           cur_x = 0;
  int                           cur_y = 0;
  bit                           sprite_over = 1'b1;

  pixel_item_t pending_pixels[$];
  int          mismatches = 0;
  int          sent_bytes = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          quiet_cycles = 0;

  rle_sprite_clip_blitter_top #(.COORD_BITS(COORD_BITS)) u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit blit_step(input byte_item_t it, output pixel_item_t px);
    bit run_end;
    int ox, oy, sw, sh, cl, ct, cr, cb;
    ox = org_x;
    oy = org_y;
    sw = spr_w;
    sh = spr_h;
    cl = clip_l;
    ct = clip_t;
    cr = clip_r;
    cb = clip_b;
    run_end = 1'b0;
    px = '0;
    if (it.first_byte) begin
      want_tag = 1'b1;
      lits_left = '0;
      cur_x = ox;
      cur_y = oy;
      sprite_over = (ox > cr) || (oy > cb) || (sh == 0);
      if (sprite_over) begin
        px.sprite_done = 1'b1;
        return 1'b1;
      end
    end else if (sprite_over) begin
      return 1'b0;
    end
    if (want_tag) begin
      if (it.rle_byte[7]) begin
        cur_x += it.rle_byte[6:0];
        run_end = 1'b1;
      end else if (it.rle_byte == 8'd0) begin
        run_end = 1'b1;
      end else begin
        lits_left = it.rle_byte[6:0];
        want_tag = 1'b0;
      end
    end else begin
      if (cur_x >= cl && cur_x <= cr && cur_y >= ct && cur_y <= cb) begin
        px.pixel_write = 1'b1;
        px.pixel_x = cur_x[CLIP_BITS-1:0];
        px.pixel_y = cur_y[CLIP_BITS-1:0];
        px.pixel_color = it.rle_byte;
      end
      cur_x++;
      lits_left = lits_left - 1'b1;
      if (lits_left == '0) begin
        want_tag = 1'b1;
        run_end = 1'b1;
      end
    end
    if (run_end && cur_x >= ox + sw) begin
      cur_x = ox;
      cur_y++;
      if (cur_y > cb || cur_y >= oy + sh)
        sprite_over = 1'b1;
    end
    px.sprite_done = sprite_over;
    return 1'b1;
  endfunction

  function automatic stim_row_t reg_row(input logic [CFG_INDEX_BITS-1:0] idx,
                                        input logic [COORD_BITS-1:0] val);
    reg_row = '0;
    reg_row.kind = ROW_REG;
    reg_row.reg_index = idx;
    reg_row.reg_value = val;
  endfunction

  function automatic stim_row_t byte_row(input logic fb, input logic [7:0] b);
    byte_row = '0;
    byte_row.kind = ROW_BYTE;
    byte_row.item = {fb, b};
  endfunction

  function automatic stim_row_t typed_row(input logic fb, input logic [7:0] b,
                                          input pixel_item_t want);
    typed_row = byte_row(fb, b);
    typed_row.typed = 1'b1;
    typed_row.want = want;
  endfunction

  task automatic cmp_field(input string name, input logic [CLIP_BITS-1:0] want,
                           input logic [CLIP_BITS-1:0] got);
    if (got !== want) begin
      $error("%s expected %0d actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_pixel(input pixel_item_t got);
    pixel_item_t want;
    if (pending_pixels.size() == 0) begin
      $error("unexpected transaction %h", got);
      mismatches++;
    end else begin
      want = pending_pixels.pop_front();
      cmp_field("pixel_write", want.pixel_write, got.pixel_write);
      cmp_field("pixel_x", want.pixel_x, got.pixel_x);
      cmp_field("pixel_y", want.pixel_y, got.pixel_y);
      cmp_field("pixel_color", want.pixel_color, got.pixel_color);
      cmp_field("sprite_done", want.sprite_done, got.sprite_done);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_pixel(pixel_item);
      pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_byte(input byte_item_t it, input logic typed, input pixel_item_t want);
    pixel_item_t px;
    bit got;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    byte_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    got = blit_step(it, px);
    if (typed) pending_pixels.push_back(want);
    else if (got) pending_pixels.push_back(px);
    sent_bytes++;
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                         input logic [COORD_BITS-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_ORIGIN_X:      org_x = val;
      REG_ORIGIN_Y:      org_y = val;
      REG_SPRITE_WIDTH:  spr_w = val[SIZE_BITS-1:0];
      REG_SPRITE_HEIGHT: spr_h = val[SIZE_BITS-1:0];
      REG_CLIP_LEFT:     clip_l = val[CLIP_BITS-1:0];
      REG_CLIP_TOP:      clip_t = val[CLIP_BITS-1:0];
      REG_CLIP_RIGHT:    clip_r = val[CLIP_BITS-1:0];
      REG_CLIP_BOTTOM:   clip_b = val[CLIP_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic rand_config();
    int w, h, cl, cr, ct, cb, ox, oy, sel;
    sel = $urandom_range(0, 19);
    w = (sel == 0) ? 0 : (sel == 1) ? 1023 : $urandom_range(1, 12);
    sel = $urandom_range(0, 19);
    h = (sel == 0) ? 0 : (sel == 1) ? 1023 : $urandom_range(1, 4);
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      cl = 0;
      ct = 0;
      cr = 2047;
      cb = 2047;
    end else if (sel == 1) begin
      // empty clip rectangle
      cl = $urandom_range(1, 2047);
      cr = $urandom_range(0, cl - 1);
      ct = $urandom_range(0, 2047);
      cb = $urandom_range(0, 2047);
    end else begin
      cl = ($urandom_range(0, 3) == 0) ? $urandom_range(2036, 2047) : $urandom_range(0, 2047);
      ct = ($urandom_range(0, 3) == 0) ? $urandom_range(2040, 2047) : $urandom_range(0, 2047);
      cr = cl + $urandom_range(0, 10);
      cb = ct + $urandom_range(0, 6);
      if (cr > 2047) cr = 2047;
      if (cb > 2047) cb = 2047;
    end
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      ox = $urandom_range(0, 1) ? 2047 : -2048;
      oy = $urandom_range(0, 1) ? 2047 : -2048;
    end else if (sel == 1) begin
      ox = $urandom_range(0, 4095) - 2048;
      oy = $urandom_range(0, 4095) - 2048;
    end else begin
      ox = cl + $urandom_range(0, 8) - 4;
      oy = ct - $urandom_range(0, 2);
      if (ox > 2047) ox = 2047;
    end
    set_reg(REG_ORIGIN_X, ox[COORD_BITS-1:0]);
    set_reg(REG_ORIGIN_Y, oy[COORD_BITS-1:0]);
    set_reg(REG_SPRITE_WIDTH, w[COORD_BITS-1:0]);
    set_reg(REG_SPRITE_HEIGHT, h[COORD_BITS-1:0]);
    set_reg(REG_CLIP_LEFT, cl[COORD_BITS-1:0]);
    set_reg(REG_CLIP_TOP, ct[COORD_BITS-1:0]);
    set_reg(REG_CLIP_RIGHT, cr[COORD_BITS-1:0]);
    set_reg(REG_CLIP_BOTTOM, cb[COORD_BITS-1:0]);
    cfg_write <= 1'b0;
  endtask

  // Mostly well-formed rows of skips and literal runs; some stray tags and overshoots.
  task automatic send_sprite();
    int col, n, k, cap, sw;
    logic fb;
    sw = spr_w;
    col = 0;
    fb = 1'b1;
    cap = $urandom_range(6, 80);
    while (cap > 0) begin
      n = sw - col;
      if (n < 1) n = 1;
      if (n > 127) n = 127;
      n = $urandom_range(1, n);
      k = $urandom_range(0, 19);
      if (k == 0) begin
        send_byte({fb, 8'($urandom_range(0, 255))}, 1'b0, '0);
        col = 0;
      end else if (k == 1) begin
        send_byte({fb, 8'h00}, 1'b0, '0);
      end else if (k < 9) begin
        if (k == 2) n = $urandom_range(1, 127);
        send_byte({fb, 8'h80 | 8'(n)}, 1'b0, '0);
        col += n;
      end else begin
        send_byte({fb, 8'(n)}, 1'b0, '0);
        repeat (n) send_byte({1'b0, 8'($urandom_range(0, 255))}, 1'b0, '0);
        col += n;
        cap -= n;
      end
      fb = 1'b0;
      cap--;
      if (col >= sw) col = 0;
    end
  endtask

  initial begin
    stim_row_t directed[$];
    bit in_cfg;
    in_cfg = 1'b0;

    directed.push_back(typed_row(1'b1, 8'h00, {1'b0, 11'd0, 11'd0, 8'd0, 1'b1}));
    directed.push_back(byte_row(1'b0, 8'h55));
    directed.push_back(reg_row(REG_SPRITE_WIDTH, 12'd4));
    directed.push_back(reg_row(REG_SPRITE_HEIGHT, 12'd2));
    directed.push_back(byte_row(1'b1, 8'h03));
    directed.push_back(typed_row(1'b0, 8'hFF, {1'b1, 11'd0, 11'd0, 8'hFF, 1'b0}));
    directed.push_back(byte_row(1'b0, 8'h00));
    directed.push_back(byte_row(1'b0, 8'h80));
    directed.push_back(byte_row(1'b0, 8'h81));
    directed.push_back(byte_row(1'b0, 8'h00));
    directed.push_back(byte_row(1'b0, 8'hFF));
    directed.push_back(byte_row(1'b0, 8'h7F));
    directed.push_back(reg_row(REG_ORIGIN_X, 12'h800));
    directed.push_back(reg_row(REG_ORIGIN_Y, 12'h7FF));
    directed.push_back(reg_row(REG_SPRITE_WIDTH, 12'd1023));
    directed.push_back(reg_row(REG_SPRITE_HEIGHT, 12'd1023));
    directed.push_back(byte_row(1'b1, 8'h7F));
    directed.push_back(byte_row(1'b0, 8'hAA));
    directed.push_back(byte_row(1'b1, 8'h01));
    directed.push_back(reg_row(REG_CLIP_RIGHT, 12'd2046));
    directed.push_back(reg_row(REG_ORIGIN_X, 12'h7FF));
    directed.push_back(typed_row(1'b1, 8'h12, {1'b0, 11'd0, 11'd0, 8'd0, 1'b1}));
    directed.push_back(reg_row(REG_ORIGIN_X, 12'd2040));
    directed.push_back(reg_row(REG_ORIGIN_Y, 12'd2046));
    directed.push_back(reg_row(REG_SPRITE_WIDTH, 12'd2));
    directed.push_back(reg_row(REG_SPRITE_HEIGHT, 12'd3));
    directed.push_back(reg_row(REG_CLIP_LEFT, 12'd2045));
    directed.push_back(reg_row(REG_CLIP_TOP, 12'd2046));
    directed.push_back(reg_row(REG_CLIP_RIGHT, 12'd2047));
    directed.push_back(reg_row(REG_CLIP_BOTTOM, 12'd2046));
    directed.push_back(byte_row(1'b1, 8'h08));
    directed.push_back(byte_row(1'b0, 8'h01));
    directed.push_back(byte_row(1'b0, 8'h02));
    directed.push_back(byte_row(1'b0, 8'h04));
    directed.push_back(byte_row(1'b0, 8'h08));
    directed.push_back(byte_row(1'b0, 8'h10));
    directed.push_back(byte_row(1'b0, 8'h20));
    directed.push_back(byte_row(1'b0, 8'h40));
    directed.push_back(typed_row(1'b0, 8'h80, {1'b1, 11'd2047, 11'd2046, 8'h80, 1'b1}));

    send_idle_pct = 32;
    recv_idle_pct = 55;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_REG) begin
        if (!in_cfg) begin
          drain();
          in_cfg = 1'b1;
        end
        set_reg(directed[i].reg_index, directed[i].reg_value);
      end else begin
        if (in_cfg) begin
          cfg_write <= 1'b0;
          in_cfg = 1'b0;
        end
        send_byte(directed[i].item, directed[i].typed, directed[i].want);
      end
    end

    sent_bytes = 0;
    while (sent_bytes < RANDOM_ITEMS) begin
      if (sent_bytes < RANDOM_ITEMS / 3) begin
        send_idle_pct = 32;
        recv_idle_pct = 55;
      end else if (sent_bytes < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 55;
        recv_idle_pct = 32;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      drain();
      rand_config();
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 4) != 0) begin
          send_sprite();
        end else begin
          repeat ($urandom_range(1, 6))
            send_byte({($urandom_range(0, 7) == 0), 8'($urandom_range(0, 255))}, 1'b0, '0);
        end
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: rle_sprite_clip_blitter_top.f
+incdir+sv
sv/rscb_pkg.sv
sv/rscb_fifo.sv
sv/rscb_front.sv
sv/rscb_back.sv
sv/rle_sprite_clip_blitter_top.sv
tb/rle_sprite_clip_blitter_top_test.sv
